### rtl/sha256_stream_hasher_assert.svh
// Assertion macros shared by the hasher modules
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// Assert an implication on the same edge, disabled in reset
`define SSH_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Assert an implication on the following edge, disabled in reset
`define SSH_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

### rtl/sha256_pkg.sv
package sha256_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Word queued from the front end to the compression engine
    typedef struct packed {
        logic [31:0] word;
        logic        last;   // final word of the padded message
    } t_blk_word;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = 2;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [3:0]  LEN_POS  = 4'd14;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] KROM [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

### rtl/sha256_front.sv
module sha256_front import sha256_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_wvalid,
    input  logic      i_wstall,
    output t_blk_word o_word
);

    typedef enum logic [3:0] {
        S_DATA = 4'b0001,
        S_ZERO = 4'b0010,
        S_LENH = 4'b0100,
        S_LENL = 4'b1000
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [63:0] r_len, n_len;
    logic [3:0]  r_pos, n_pos;
    logic        r_pend, n_pend;   // 0x80 word still owed after a full final word
    logic [2:0]  nb;
    logic [31:0] mask, padded;
    logic        push;

    // Clamp the byte count and build the padded final word
    always_comb begin
        nb = (i_item.valid_bytes > 3'd4) ? 3'd4 : i_item.valid_bytes;
        case (nb)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'hff00_0000;
            3'd2:    mask = 32'hffff_0000;
            3'd3:    mask = 32'hffff_ff00;
            default: mask = 32'hffff_ffff;
        endcase
        padded = (i_item.data_word & mask) | (PAD_WORD >> {nb, 3'b000});
    end

    assign push    = o_wvalid && !i_wstall;
    assign o_stall = (r_state != S_DATA) || r_pend || i_wstall;

    // Choose the word to send and advance the padding sequencer
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_pos   = r_pos;
        n_pend  = r_pend;
        o_wvalid = 1'b0;
        o_word   = '{word: 32'd0, last: 1'b0};
        case (r_state)
            S_DATA: begin
                if (r_pend) begin
                    o_wvalid = 1'b1;
                    o_word.word = PAD_WORD;
                end else if (i_valid) begin
                    o_wvalid = 1'b1;
                    if (!i_item.end_of_message) begin
                        o_word.word = i_item.data_word;
                    end else if (nb == 3'd4) begin
                        o_word.word = i_item.data_word;
                    end else begin
                        o_word.word = padded;
                    end
                end
                if (push) begin
                    n_pos = r_pos + 4'd1;
                    if (r_pend) begin
                        n_pend  = 1'b0;
                        n_state = (r_pos + 4'd1 == LEN_POS) ? S_LENH : S_ZERO;
                    end else if (!i_item.end_of_message) begin
                        n_len = r_len + 64'd32;
                    end else begin
                        n_len = r_len + {58'd0, nb, 3'b000};
                        if (nb == 3'd4) begin
                            n_pend = 1'b1;
                        end else begin
                            n_state = (r_pos + 4'd1 == LEN_POS) ? S_LENH : S_ZERO;
                        end
                    end
                end
            end
            S_ZERO: begin
                o_wvalid = 1'b1;
                if (push) begin
                    n_pos = r_pos + 4'd1;
                    if (r_pos + 4'd1 == LEN_POS) n_state = S_LENH;
                end
            end
            S_LENH: begin
                o_wvalid = 1'b1;
                o_word.word = r_len[63:32];
                if (push) begin
                    n_pos = r_pos + 4'd1;
                    n_state = S_LENL;
                end
            end
            S_LENL: begin
                o_wvalid = 1'b1;
                o_word.word = r_len[31:0];
                o_word.last = 1'b1;
                if (push) begin
                    n_pos   = 4'd0;
                    n_len   = 64'd0;
                    n_state = S_DATA;
                end
            end
            default: n_state = S_DATA;
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DATA;
            r_len   <= 64'd0;
            r_pos   <= 4'd0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_pend  <= n_pend;
        end
    end

`include "sha256_stream_hasher_assert.svh"
    `SSH_ASSERT_IMP(a_len_pos, i_clk, i_rst_n, r_state == S_LENL, r_pos == 4'd15)
    `SSH_ASSERT_IMP(a_pend_data, i_clk, i_rst_n, r_pend, r_state == S_DATA)
    `SSH_ASSERT_NEXT(a_last_wrap, i_clk, i_rst_n, push && o_word.last, r_pos == 4'd0)

endmodule

### rtl/sha256_queue.sv
module sha256_queue import sha256_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_blk_word i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_blk_word o_word
);

    t_blk_word      r_mem [QDEPTH];
    logic [QAW:0]   r_cnt;
    logic [QAW-1:0] r_wp, r_rp;
    logic           wr, rd;

    assign o_stall = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rp];
    assign wr = i_valid && !o_stall;
    assign rd = o_valid && !i_stall;

    // Store incoming words
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_word;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(wr) - (QAW+1)'(rd);
        end
    end

`include "sha256_stream_hasher_assert.svh"
    `SSH_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (QAW+1)'(QDEPTH))
    `SSH_ASSERT_NEXT(a_q_nofill, i_clk, i_rst_n, wr && !rd, r_cnt != '0)
    `SSH_ASSERT_IMP(a_q_ptr, i_clk, i_rst_n, r_cnt == '0, r_wp == r_rp)

endmodule

### rtl/sha256_core.sv
module sha256_core import sha256_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_blk_word i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    typedef enum logic [3:0] {
        C_LOAD  = 4'b0001,
        C_ROUND = 4'b0010,
        C_ADD   = 4'b0100,
        C_OUT   = 4'b1000
    } t_cstate;

    t_cstate     r_state;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [3:0]  r_cnt;
    logic [5:0]  r_rnd;
    logic        r_last;
    logic [2:0]  r_oidx;
    logic [31:0] wt, s0, s1, t1, t2, kt;
    logic        take;

    assign take    = (r_state == C_LOAD) && i_valid;
    assign o_stall = (r_state != C_LOAD);
    assign o_valid = (r_state == C_OUT);
    assign o_item  = '{digest_word: r_h[r_oidx], word_index: r_oidx,
                       last_word: (r_oidx == 3'd7)};

    // Schedule word and round function; window shifts so slot 0 is W[t]
    always_comb begin
        kt = KROM[r_rnd];
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wt = s1 + r_w[9] + s0 + r_w[0];
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + kt + r_w[0];
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Load, compress, accumulate and drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_LOAD;
            r_cnt   <= 4'd0;
            r_rnd   <= 6'd0;
            r_last  <= 1'b0;
            r_oidx  <= 3'd0;
            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
        end else begin
            case (r_state)
                C_LOAD: begin
                    if (take) begin
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                        r_w[15] <= i_word.word;
                        r_cnt   <= r_cnt + 4'd1;
                        if (r_cnt == 4'd15) begin
                            r_last  <= i_word.last;
                            r_rnd   <= 6'd0;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            r_state <= C_ROUND;
                        end
                    end
                end
                C_ROUND: begin
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wt;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= C_ADD;
                end
                C_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oidx  <= 3'd0;
                    r_state <= r_last ? C_OUT : C_LOAD;
                end
                C_OUT: begin
                    if (!i_stall) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
                            r_state <= C_LOAD;
                        end
                    end
                end
                default: r_state <= C_LOAD;
            endcase
        end
    end

`include "sha256_stream_hasher_assert.svh"
    `SSH_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `SSH_ASSERT_IMP(a_cnt_rnd, i_clk, i_rst_n, r_state == C_ROUND, r_cnt == 4'd0)
    `SSH_ASSERT_NEXT(a_out_adv, i_clk, i_rst_n, o_valid && !i_stall && r_oidx != 3'd7,
        o_valid)

endmodule

### rtl/sha256_stream_hasher.sv
// SHA-256 hasher over a stream of big-endian 32-bit message words. A front
// sequencer counts the message length and appends the 0x80 byte, zero fill and
// the 64-bit bit length, adding a block when needed; a four-word queue feeds a
// compression engine that loads 16 words (one a cycle while the queue has one),
// then runs 64 rounds at one round per cycle and adds the result into the hash;
// it takes no new words meanwhile, so throughput is set by the single round unit.
// After the final block the eight digest words are sent, index 0 first, and
// the hash returns to the initial value for the next message.
module sha256_stream_hasher import sha256_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic      f_valid, f_stall, q_valid, q_stall;
    t_blk_word f_word, q_word;

    sha256_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .o_wvalid(f_valid), .i_wstall(f_stall), .o_word(f_word));

    sha256_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_stall(f_stall), .i_word(f_word),
        .o_valid(q_valid), .i_stall(q_stall), .o_word(q_word));

    sha256_core u_core (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_stall(q_stall), .i_word(q_word),
        .o_valid, .i_stall, .o_item);

endmodule

### tb/testbench.sv
module testbench;
    import sha256_pkg::*;

    localparam int RANDOM_ITEMS = 70;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 300;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    sha256_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // Predictor state
    logic [31:0] hash_state [8];
    logic [31:0] msg_block [16];
    logic [63:0] bit_count;
    int          word_pos;

    t_out_item   digest_queue [$];
    int          fail_count;
    int          idle_cycles;
    bit          long_hold;

    // Directed stimulus; expected first digest words for the empty message and "abc" are typed in
    typedef struct {
        t_in_item    item;
        bit          known;
        logic [31:0] first_word;
    } t_stim_row;

    t_stim_row stim_table [$];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run 64 rounds over the assembled block and fold into the hash
    task automatic compress_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                sched[t] = msg_block[t];
            end else begin
                s0 = ror(sched[t-15], 7) ^ ror(sched[t-15], 18) ^ (sched[t-15] >> 3);
                s1 = ror(sched[t-2], 17) ^ ror(sched[t-2], 19) ^ (sched[t-2] >> 10);
                sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
            end
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + KROM[t] + sched[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic append_word(input logic [31:0] w);
        msg_block[word_pos] = w;
        word_pos = (word_pos + 1) % 16;
        if (word_pos == 0) compress_block();
    endtask

    task automatic clear_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
        bit_count = '0;
        word_pos  = 0;
    endtask

    // Advance the predictor by one transfer; queue a digest at end of message
    task automatic hash_word(input t_in_item it);
        int          n;
        logic [31:0] mask;
        t_out_item   res;
        if (!it.end_of_message) begin
            append_word(it.data_word);
            bit_count += 64'd32;
            return;
        end
        n = (it.valid_bytes > 3'd4) ? 4 : int'(it.valid_bytes);
        bit_count += 64'(n * 8);
        if (n == 4) begin
            append_word(it.data_word);
            append_word(PAD_WORD);
        end else begin
            mask = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
            append_word((it.data_word & mask) | (32'h80 << (24 - 8 * n)));
        end
        while (word_pos != 14) append_word(32'h0);
        append_word(bit_count[63:32]);
        append_word(bit_count[31:0]);
        for (int i = 0; i < 8; i++) begin
            res.digest_word = hash_state[i];
            res.word_index  = 3'(i);
            res.last_word   = (i == 7);
            digest_queue.push_back(res);
        end
        clear_hash();
    endtask

    function automatic t_in_item make_item(input logic [31:0] d, input int n, input bit eom);
        t_in_item it;
        it.data_word      = d;
        it.valid_bytes    = 3'(n);
        it.end_of_message = eom;
        return it;
    endfunction

    function automatic t_in_item random_word(input bit eom);
        return make_item($urandom, $urandom_range(0, 7), eom);
    endfunction

    // Offer one item; hold it until the block takes it
    task automatic send_item(input t_in_item it);
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        hash_word(it);
        @(negedge i_clk);
    endtask

    task automatic add_row(input t_in_item it, input bit known, input logic [31:0] w0);
        t_stim_row r;
        r.item = it; r.known = known; r.first_word = w0;
        stim_table.push_back(r);
    endtask

    // Receiver stall pattern, with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n || long_hold) i_stall <= long_hold;
        else i_stall <= ($urandom_range(0, 9) < 3);
    end

    // Check each digest transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_queue.size() == 0) begin
                $error("unexpected digest word %h", o_item.digest_word);
                fail_count++;
            end else begin
                exp_item = digest_queue.pop_front();
                if (o_item.digest_word !== exp_item.digest_word) begin
                    $error("digest_word: expected %h, got %h",
                           exp_item.digest_word, o_item.digest_word);
                    fail_count++;
                end
                if (o_item.word_index !== exp_item.word_index) begin
                    $error("word_index: expected %0d, got %0d",
                           exp_item.word_index, o_item.word_index);
                    fail_count++;
                end
                if (o_item.last_word !== exp_item.last_word) begin
                    $error("last_word: expected %0d, got %0d",
                           exp_item.last_word, o_item.last_word);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int msg_len;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_item      = '0;
        fail_count  = 0;
        idle_cycles = 0;
        long_hold   = 1'b0;
        clear_hash();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message: well-known digest e3b0c442...
        add_row(make_item(32'h0, 0, 1'b1), 1'b1, 32'he3b0c442);
        // "abc": ba7816bf...
        add_row(make_item(32'h6162_63ff, 3, 1'b1), 1'b1, 32'hba7816bf);
        // Valid count above four, full final word, all ones
        add_row(make_item(32'hffff_ffff, 7, 1'b1), 1'b0, '0);
        add_row(make_item(32'h0000_0000, 4, 1'b1), 1'b0, '0);
        // Short word mid-message taken as four bytes, then one byte at end
        add_row(make_item(32'h1234_5678, 1, 1'b0), 1'b0, '0);
        add_row(make_item(32'hffff_ffff, 1, 1'b1), 1'b0, '0);
        // Fourteen words: the padding and length still fit in the same block
        for (int i = 0; i < 13; i++)
            add_row(make_item(32'ha5a5_0000 + 32'(i), 4, 1'b0), 1'b0, '0);
        add_row(make_item(32'h5a5a_5a5a, 2, 1'b1), 1'b0, '0);

        foreach (stim_table[r]) begin
            if (stim_table[r].known) begin
                send_item(stim_table[r].item);
                if (digest_queue[$-7].digest_word !== stim_table[r].first_word) begin
                    $error("digest_word: expected %h, got %h",
                           stim_table[r].first_word, digest_queue[$-7].digest_word);
                    fail_count++;
                end
            end else begin
                send_item(stim_table[r].item);
            end
        end

        // Long receiver hold-off while the sender feeds a short message and then a long one
        fork
            begin
                long_hold <= 1'b1;
                repeat (400) @(negedge i_clk);
                long_hold <= 1'b0;
            end
            begin
                for (int i = 0; i < 20; i++) send_item(random_word(i == 2 || i == 19));
            end
        join

        // Random messages of 1 to 18 words, about one in five of 16 words to hit the length rule
        for (int sent = 0; sent < RANDOM_ITEMS; sent += msg_len) begin
            msg_len = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 18);
            for (int i = 0; i < msg_len; i++) send_item(random_word(i == msg_len - 1));
        end
        i_valid <= 1'b0;

        wait (digest_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
